// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SDTQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SDTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/sdtq_pkg.sv
package sdtq_pkg;

  localparam int TICK_W = 64;
  localparam int ID_W = 8;
  localparam int TPS_W = 16;
  localparam int MS_W = 31;
  localparam int PROD_W = TPS_W + MS_W;
  localparam int MS_PER_SEC = 1000;
  localparam int REM_W = $clog2(MS_PER_SEC);
  localparam int KIND_W = 2;

  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(100);

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WAKE = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [ID_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic start;
    logic [TPS_W-1:0] tps;
    logic [MS_W-1:0] ms;
    logic [TICK_W-1:0] now;
  } dly_req_t;

  typedef struct packed {
    logic done;
    logic [TICK_W-1:0] deadline;
  } dly_rsp_t;

endpackage

// File: rtl/sdtq_delay.sv
module sdtq_delay
  import sdtq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  dly_req_t req,
  output dly_rsp_t rsp
);

  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_MUL = 3'd1;
  localparam logic [2:0] D_QUO = 3'd2;
  localparam logic [2:0] D_REM = 3'd3;
  localparam logic [2:0] D_ADD = 3'd4;
  localparam int DIG_W = 16;
  localparam int N_DIG = (PROD_W + DIG_W - 1) / DIG_W;
  localparam int QW = N_DIG * DIG_W;
  localparam int CNT_W = $clog2(N_DIG + 1);
  localparam int DIV_W = REM_W + DIG_W;
  localparam int RECIP_SH = 36;
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(MS_PER_SEC) - 64'd1) / 64'(MS_PER_SEC));
  localparam int MUL_W = DIV_W + RECIP_W;

  logic [2:0] state;
  logic [CNT_W-1:0] cnt;
  logic [TPS_W-1:0] tps;
  logic [MS_W-1:0] ms;
  logic [TICK_W-1:0] now;
  logic [QW-1:0] prod;
  logic [REM_W-1:0] rem;
  logic [DIG_W-1:0] digit;
  logic [DIV_W-1:0] dividend;
  logic [MUL_W-1:0] scaled;
  logic [DIV_W-1:0] back;
  logic [DIV_W-1:0] rem_full;
  logic [TICK_W:0] sum;
  logic done;
  logic [TICK_W-1:0] deadline;

  assign dividend = {rem, prod[QW-1 -: DIG_W]};
  assign scaled = MUL_W'(dividend) * MUL_W'(RECIP);
  assign back = DIV_W'(digit) * DIV_W'(MS_PER_SEC);
  assign rem_full = dividend - back;
  assign sum = {1'b0, now} + (TICK_W + 1)'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            tps <= req.tps;
            ms <= req.ms;
            now <= req.now;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          prod <= QW'(PROD_W'(tps) * PROD_W'(ms));
          rem <= '0;
          cnt <= CNT_W'(N_DIG);
          state <= D_QUO;
        end
        D_QUO: begin
          // quotient digit by reciprocal multiply
          digit <= scaled[RECIP_SH +: DIG_W];
          state <= D_REM;
        end
        D_REM: begin
          rem <= rem_full[REM_W-1:0];
          prod <= {prod[QW-DIG_W-1:0], digit};
          cnt <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            state <= D_ADD;
          end else begin
            state <= D_QUO;
          end
        end
        D_ADD: begin
          // saturate on carry out
          deadline <= sum[TICK_W] ? '1 : sum[TICK_W-1:0];
          done <= 1'b1;
          state <= D_IDLE;
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.deadline = deadline;

endmodule

// File: rtl/sdtq_store.sv
module sdtq_store
  import sdtq_pkg::*;
#(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/sleep_deadline_timer_queue.sv
// channel  direction  handshake                payload
// in       input      in_valid / in_ready      req_type, sleeper_id, sleep_ms
// out      output     out_valid / out_ready    result_kind, woken_id, now_ticks, last
// cfg      input      cfg_we                   cfg_wdata (ticks_per_second)
//
// sleep request: the delay unit multiplies, then divides by 1000 in three 16-bit digits, then
//   adds; insertion then steps past each queued entry with a later deadline
// tick: due entries are released from the head one by one; rst is synchronous, queue starts empty
// a stalled out channel holds the sequencer at its next result; in_ready is low
//   from acceptance until the last result of the transaction is loaded
module sleep_deadline_timer_queue
  import sdtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TPS_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              req_type,
  input  logic [ID_W-1:0]   sleeper_id,
  input  logic [MS_W-1:0]   sleep_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] result_kind,
  output logic [ID_W-1:0]   woken_id,
  output logic [TICK_W-1:0] now_ticks,
  output logic              last
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DLY = 4'd1;
  localparam logic [3:0] S_IRD = 4'd2;
  localparam logic [3:0] S_ICMP = 4'd3;
  localparam logic [3:0] S_IWR = 4'd4;
  localparam logic [3:0] S_EMIT = 4'd5;
  localparam logic [3:0] S_RRD = 4'd6;
  localparam logic [3:0] S_RCMP = 4'd7;
  localparam logic [3:0] S_RFIN = 4'd8;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW+1:0] s;
    s = (AW + 2)'(base) + (AW + 2)'(off);
    if (s >= (AW + 2)'(QUEUE_DEPTH)) begin
      s = s - (AW + 2)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [3:0] state;
  logic [TPS_W-1:0] tps;
  logic [TICK_W-1:0] tick_count;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;
  logic [TICK_W-1:0] dl;
  logic [ID_W-1:0] id;
  logic [KIND_W-1:0] emit_kind;
  logic pend;
  logic [ID_W-1:0] pend_id;

  dly_req_t dreq;
  dly_rsp_t drsp;

  logic mem_we;
  logic mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  entry_t mem_wdata;
  entry_t mem_rdata;

  logic ofree;
  logic accept;
  logic full;
  logic later;
  logic due;
  logic load;
  logic [KIND_W-1:0] load_kind;
  logic [ID_W-1:0] load_id;
  logic load_last;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;
  assign full = (count == CW'(QUEUE_DEPTH));
  assign ofree = !out_valid || out_ready;
  assign later = mem_rdata.deadline > dl;
  assign due = mem_rdata.deadline < tick_count;

  assign dreq.start = accept && !req_type && !full;
  assign dreq.tps = tps;
  assign dreq.ms = sleep_ms;
  assign dreq.now = tick_count;

  sdtq_delay u_delay (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign mem_waddr = wrap_add(head, pos);
  assign mem_we = ((state == S_ICMP) && later) || (state == S_IWR);
  assign mem_wdata = (state == S_IWR) ? entry_t'{deadline: dl, owner: id} : mem_rdata;
  assign mem_re = ((state == S_IRD) && (pos != '0)) || ((state == S_RRD) && (count != '0));
  assign mem_raddr = (state == S_IRD) ? wrap_add(head, pos - CW'(1)) : head;

  sdtq_store #(
    .DEPTH (QUEUE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    load = 1'b0;
    load_kind = emit_kind;
    load_id = '0;
    load_last = 1'b1;
    case (state)
      S_EMIT: begin
        load = ofree;
      end
      S_RCMP: begin
        load = due && pend && ofree;
        load_kind = KIND_WAKE;
        load_id = pend_id;
        load_last = 1'b0;
      end
      S_RFIN: begin
        load = pend && ofree;
        load_kind = KIND_WAKE;
        load_id = pend_id;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tps <= TPS_RESET;
      tick_count <= '0;
      head <= '0;
      count <= '0;
      pend <= 1'b0;
    end else begin
      if (cfg_we) begin
        tps <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend <= 1'b0;
            id <= sleeper_id;
            if (req_type) begin
              tick_count <= tick_count + TICK_W'(1);
              state <= S_RRD;
            end else if (full) begin
              emit_kind <= KIND_REJECT;
              state <= S_EMIT;
            end else begin
              state <= S_DLY;
            end
          end
        end
        S_DLY: begin
          if (drsp.done) begin
            dl <= drsp.deadline;
            pos <= count;
            state <= S_IRD;
          end
        end
        S_IRD: begin
          state <= (pos == '0) ? S_IWR : S_ICMP;
        end
        S_ICMP: begin
          if (later) begin
            pos <= pos - CW'(1);
            state <= S_IRD;
          end else begin
            state <= S_IWR;
          end
        end
        S_IWR: begin
          count <= count + CW'(1);
          emit_kind <= KIND_ACCEPT;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (ofree) begin
            state <= S_IDLE;
          end
        end
        S_RRD: begin
          state <= (count == '0) ? S_RFIN : S_RCMP;
        end
        S_RCMP: begin
          if (!due) begin
            state <= S_RFIN;
          end else if (!pend || ofree) begin
            pend <= 1'b1;
            pend_id <= mem_rdata.owner;
            head <= wrap_add(head, CW'(1));
            count <= count - CW'(1);
            state <= S_RRD;
          end
        end
        S_RFIN: begin
          if (!pend || ofree) begin
            pend <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_kind <= load_kind;
      woken_id <= load_id;
      now_ticks <= tick_count;
      last <= load_last;
    end
  end

endmodule

// File: rtl/sdtq_checker.sv
`include "assert_macros.svh"

module sdtq_checker
  import sdtq_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] result_kind,
  input logic [ID_W-1:0]   woken_id,
  input logic [TICK_W-1:0] now_ticks,
  input logic              last
);

  logic stalled;
  logic reply;
  logic [KIND_W+ID_W+TICK_W:0] out_word;

  assign stalled = out_valid && !out_ready;
  assign reply = out_valid && (result_kind != KIND_WAKE);
  assign out_word = {result_kind, woken_id, now_ticks, last};

  `SDTQ_ASSERT_NEXT(a_out_hold, stalled, out_valid && $stable(out_word), "stalled result changed")
  `SDTQ_ASSERT_SAME(a_reply_single, reply, last && (woken_id == '0), "reply not final or has id")
  `SDTQ_ASSERT_SAME(a_busy_mid, out_valid && !last, !in_ready, "ready mid transaction")
  `SDTQ_ASSERT_NEXT(a_busy_after, in_valid && in_ready, !in_ready, "ready after acceptance")

endmodule

bind sleep_deadline_timer_queue sdtq_checker u_sdtq_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import sdtq_pkg::*;

  localparam int QUEUE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 250;
  localparam int LONG_HOLD = 600;
  localparam int MAX_PRINTS = 60;

  localparam logic REQ_SLEEP = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic op;
    logic [ID_W-1:0] id;
    logic [MS_W-1:0] ms;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0] id;
    logic [TICK_W-1:0] ticks;
    logic last;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [TPS_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = 1'b0;
  logic [ID_W-1:0] sleeper_id = '0;
  logic [MS_W-1:0] sleep_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] result_kind;
  logic [ID_W-1:0] woken_id;
  logic [TICK_W-1:0] now_ticks;
  logic last;

  request_t pending_reqs[$];
  request_t offered;
  outcome_t due_results[$];
  entry_t sleepers[$];
  logic [TICK_W-1:0] model_now = '0;
  logic [TPS_W-1:0] model_tps = TPS_RESET;

  int error_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int burst_left = 1;
  int gap_left = 0;
  int drain_cycle = 0;
  int stall_hold = 0;
  int next_hold_at = 12;

  sleep_deadline_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .sleeper_id(sleeper_id),
    .sleep_ms(sleep_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .woken_id(woken_id),
    .now_ticks(now_ticks),
    .last(last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (error_count < MAX_PRINTS)
      $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic void add_request(input logic op, input logic [ID_W-1:0] id,
                                      input logic [MS_W-1:0] ms);
    request_t r;
    r.op = op;
    r.id = id;
    r.ms = ms;
    pending_reqs.push_back(r);
  endfunction

  function automatic void note_result(input logic [KIND_W-1:0] kind,
                                      input logic [ID_W-1:0] id, input logic is_last);
    outcome_t o;
    o.kind = kind;
    o.id = id;
    o.ticks = model_now;
    o.last = is_last;
    due_results.push_back(o);
  endfunction

  function automatic void apply_request(input request_t r);
    logic [PROD_W-1:0] product;
    logic [TICK_W:0] sum;
    logic [TICK_W-1:0] deadline;
    entry_t e;
    int pos;
    int n;
    if (r.op == REQ_SLEEP) begin
      product = PROD_W'(model_tps) * PROD_W'(r.ms);
      sum = {1'b0, model_now} + (TICK_W + 1)'(product / PROD_W'(MS_PER_SEC));
      deadline = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
      if (sleepers.size() >= QUEUE_DEPTH) begin
        note_result(KIND_REJECT, '0, 1'b1);
      end else begin
        pos = sleepers.size();
        while (pos > 0 && sleepers[pos-1].deadline > deadline) pos--;
        e.deadline = deadline;
        e.owner = r.id;
        sleepers.insert(pos, e);
        note_result(KIND_ACCEPT, '0, 1'b1);
      end
    end else begin
      model_now = model_now + 1'b1;
      n = 0;
      while (n < sleepers.size() && sleepers[n].deadline < model_now) n++;
      for (int i = 0; i < n; i++) begin
        note_result(KIND_WAKE, sleepers[0].owner, i == n - 1);
        void'(sleepers.pop_front());
      end
    end
  endfunction

  task automatic plan_random(input int count, input logic [MS_W-1:0] ms_hi);
    int made;
    int pick;
    int group;
    logic [MS_W-1:0] shared_ms;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        add_request(REQ_TICK, ID_W'($urandom), MS_W'($urandom));
        made++;
      end else if (pick < 8) begin
        add_request(REQ_SLEEP, ID_W'($urandom), MS_W'($urandom_range(0, ms_hi)));
        made++;
      end else begin
        // equal deadlines, then a tick
        group = $urandom_range(2, 4);
        shared_ms = MS_W'($urandom_range(0, ms_hi));
        repeat (group) add_request(REQ_SLEEP, ID_W'($urandom), shared_ms);
        add_request(REQ_TICK, ID_W'($urandom), MS_W'($urandom));
        made += group + 1;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_rate(input logic [TPS_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    model_tps = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    logic fire;
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) apply_request(offered);
      if (!in_valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          offered = pending_reqs.pop_front();
          req_type <= offered.op;
          sleeper_id <= offered.id;
          sleep_ms <= offered.ms;
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_hold = 0;
    end else begin
      drain_cycle++;
      if (stall_hold == 0 && results_seen >= next_hold_at) begin
        stall_hold = LONG_HOLD;
        next_hold_at += 150;
      end
      if (stall_hold > 0) begin
        stall_hold--;
        out_ready <= 1'b0;
      end else begin
        case ((drain_cycle / 400) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ((drain_cycle % 7) >= 3);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected transaction", 64'(result_kind), 64'd0);
      end else begin
        want = due_results.pop_front();
        if (result_kind !== want.kind)
          flag_mismatch("result_kind", 64'(result_kind), 64'(want.kind));
        if (woken_id !== want.id)
          flag_mismatch("woken_id", 64'(woken_id), 64'(want.id));
        if (now_ticks !== want.ticks)
          flag_mismatch("now_ticks", now_ticks, want.ticks);
        if (last !== want.last)
          flag_mismatch("last", 64'(last), 64'(want.last));
      end
    end
  end

  initial begin
    logic [TPS_W-1:0] rate;
    int ms_cap;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset rate, truncation and equal deadlines
    add_request(REQ_TICK, 8'h3C, 31'h55);
    add_request(REQ_SLEEP, 8'h00, 31'd0);
    add_request(REQ_SLEEP, 8'hFF, 31'h7FFFFFFF);
    add_request(REQ_SLEEP, 8'hA5, 31'd10);
    add_request(REQ_SLEEP, 8'h5A, 31'd10);
    add_request(REQ_SLEEP, 8'h03, 31'd19);
    add_request(REQ_TICK, 8'hFF, 31'h7FFFFFFF);
    add_request(REQ_TICK, 8'h00, 31'd0);
    add_request(REQ_TICK, 8'h81, 31'h2AAAAAAA);
    wait_idle();

    // zero rate: deadline is the current count
    set_rate(16'h0000);
    add_request(REQ_SLEEP, 8'h00, 31'h7FFFFFFF);
    add_request(REQ_SLEEP, 8'hFF, 31'd0);
    add_request(REQ_SLEEP, 8'h81, 31'h40000001);
    add_request(REQ_TICK, 8'h7E, 31'h15555555);
    plan_random(6, 31'h7FFFFFFF);
    wait_idle();

    set_rate(16'hFFFF);
    add_request(REQ_SLEEP, 8'h11, 31'd1);
    plan_random(6, 31'd1);
    wait_idle();

    // one ms short of a tick, then exactly one tick
    set_rate(16'h0001);
    add_request(REQ_SLEEP, 8'h01, 31'd999);
    add_request(REQ_SLEEP, 8'h02, 31'd1000);
    add_request(REQ_TICK, 8'h00, 31'd0);
    add_request(REQ_TICK, 8'h00, 31'd0);
    plan_random(6, 31'd8000);
    wait_idle();

    repeat (2) begin
      rate = TPS_W'($urandom_range(2, 65534));
      set_rate(rate);
      ms_cap = 8000 / rate;
      plan_random(4, MS_W'((ms_cap > 1) ? ms_cap : 1));
      wait_idle();
    end

    // fill the queue past its depth
    set_rate(16'd500);
    repeat (66) add_request(REQ_SLEEP, ID_W'($urandom), MS_W'($urandom));
    repeat (3) add_request(REQ_TICK, ID_W'($urandom), MS_W'($urandom));
    wait_idle();

    if (error_count == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
